// ----- design/uv_sphere_vertex_index_generator_core_defines.svh -----
// Assertion macros shared by the checker of the sphere vertex generator.
// No dependencies; take in by `include before use.
`ifndef UV_SPHERE_VERTEX_INDEX_GENERATOR_CORE_DEFINES_SVH
`define UV_SPHERE_VERTEX_INDEX_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define UVSG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define UVSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define UVSG_ASSERT_NEXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/uvsg_pkg.sv -----
// Package of the sphere vertex generator: register codes, CORDIC constants,
// item record and rounding helpers. No dependencies.
package uvsg_pkg;

  localparam logic [1:0] CFG_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_SLICES  = 2'd1;
  localparam logic [1:0] CFG_STACKS  = 2'd2;
  localparam logic [1:0] CFG_REVERSE = 2'd3;

  localparam int DIV_BITS     = 40;
  localparam int DIV_PER_STG  = 4;
  localparam int DIV_STAGES   = DIV_BITS / DIV_PER_STG;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = 10;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] UNIT_POS = 16'sd16384;
  localparam logic signed [15:0] UNIT_NEG = -16'sd16384;

  localparam logic [31:0] ATAN_PHASE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861
  };

  typedef struct packed {
    logic                   mode;
    logic                   bad;
    logic                   pole_top;
    logic                   pole_bot;
    logic [15:0]            vidx;
    logic [8:0]             s1;
    logic [3:0][7:0]        rem;
    logic [3:0][39:0]       num;
    logic signed [15:0]     nx;
    logic signed [15:0]     ny;
    logic signed [15:0]     nz;
    logic signed [16:0]     px;
    logic signed [16:0]     py;
    logic signed [16:0]     pz;
  } item_t;

  // round to nearest, ties away from zero, then drop n bits
  function automatic logic signed [39:0] rnd_shift(input logic signed [39:0] v,
                                                   input logic [4:0] n);
    logic signed [39:0] half;
    half = 40'sd1 <<< (n - 5'd1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [39:0] v);
    if (v > 40'sd16384) return UNIT_POS;
    if (v < -40'sd16384) return UNIT_NEG;
    return v[15:0];
  endfunction

  // one restoring long-division step on {remainder, dividend/quotient}
  function automatic logic [47:0] div_step(input logic [47:0] acc, input logic [7:0] d);
    logic [48:0] sh;
    logic [8:0]  trial;
    sh    = {acc, 1'b0};
    trial = sh[48:40] - {1'b0, d};
    if (sh[48:40] >= {1'b0, d}) return {trial[7:0], sh[39:1], 1'b1};
    return {sh[47:40], sh[39:0]};
  endfunction

endpackage

// ----- design/uv_sphere_vertex_index_generator_core.sv -----
// UV-sphere tessellator. A mode 0 item names grid vertex (stack, slice) and
// yields one result: index, Q1.14 normal, Q9.8 position and Q1.16 UV. A mode 1
// item names a quad and yields six triangle indices, tlast on the sixth. A
// request outside the grid yields one result with tuser set and zero data.
// One item is taken per cycle while the output does not stall; a quad item
// holds the input until its six indices are taken. The pipe holds the
// long dividers (40 quotient bits, four per stage) followed by the two
// pipelined CORDIC units (sixteen iterations, two per stage). Write the
// registers only while the block is empty.
module uv_sphere_vertex_index_generator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // stack_index[7:0], slice_index[15:8]
  input  logic [0:0]   in_tuser,   // mode[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // vert_num[15:0], normal_x[31:16], normal_y[47:32], normal_z[63:48],
  // position_x[80:64], position_y[97:81], position_z[114:98],
  // tex_u[131:115], tex_v[148:132], zero[151:149]
  output logic [151:0] out_tdata,
  output logic [0:0]   out_tuser,  // bad_request[0]
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import uvsg_pkg::*;

  localparam int NST   = 2 + DIV_STAGES + CORDIC_LAT + 1;
  localparam int S_DIV = DIV_STAGES;
  localparam int S_NRM = DIV_STAGES + CORDIC_LAT + 1;
  localparam int S_POS = NST - 1;

  logic [15:0] radius_r;
  logic [7:0]  slices_r, stacks_r;
  logic        rev_r;

  item_t pipe_r [NST];
  item_t pipe_nxt [NST];
  logic  vld_r [NST];
  item_t prep;
  item_t out_item_r;
  logic  out_valid_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic  adv, out_last;
  logic signed [15:0] cos_t, sin_t, cos_p, sin_p;
  logic [31:0] ph_t, ph_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      slices_r <= 8'd16;
      stacks_r <= 8'd16;
      rev_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS:  radius_r <= cfg_wdata;
        CFG_SLICES:  slices_r <= cfg_wdata[7:0];
        CFG_STACKS:  stacks_r <= cfg_wdata[7:0];
        CFG_REVERSE: rev_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]  st, sl;
    logic [16:0] prod;
    st   = in_tdata[7:0];
    sl   = in_tdata[15:8];
    prep = '0;
    prep.mode = in_tuser[0];
    if (in_tuser[0])
      prep.bad = (slices_r == '0) || (stacks_r == '0) || (st >= stacks_r) || (sl >= slices_r);
    else
      prep.bad = (slices_r == '0) || (stacks_r == '0) || (st > stacks_r) || (sl > slices_r);
    prep.pole_top = (st == '0);
    prep.pole_bot = (st == stacks_r);
    prep.s1   = {1'b0, slices_r} + 9'd1;
    prod      = st * prep.s1;
    prep.vidx = 16'(prod + {9'd0, sl});
    prep.num[0] = {1'b0, st, 31'd0} + {33'd0, stacks_r[7:1]};
    prep.num[1] = {sl, 32'd0} + {33'd0, slices_r[7:1]};
    prep.num[2] = {16'd0, sl, 16'd0} + {33'd0, slices_r[7:1]};
    prep.num[3] = {16'd0, st, 16'd0} + {33'd0, stacks_r[7:1]};
  end

  always_comb begin
    item_t              t;
    logic [47:0]        acc;
    logic [7:0]         dv;
    logic signed [31:0] prx, prz;
    logic signed [32:0] qx, qy, qz;
    logic signed [16:0] rad;
    rad = $signed({1'b0, radius_r});
    acc = '0;
    dv  = '0;
    prx = '0;
    prz = '0;
    qx  = '0;
    qy  = '0;
    qz  = '0;
    for (int g = 0; g < NST; g++) begin
      t = (g == 0) ? prep : pipe_r[(g == 0) ? 0 : g - 1];
      if (g >= 1 && g <= S_DIV) begin
        for (int l = 0; l < 4; l++) begin
          dv  = (l == 0 || l == 3) ? stacks_r : slices_r;
          acc = {t.rem[l], t.num[l]};
          for (int s = 0; s < DIV_PER_STG; s++) acc = div_step(acc, dv);
          {t.rem[l], t.num[l]} = acc;
        end
      end
      if (g == S_NRM) begin
        prx = sin_t * cos_p;
        prz = sin_t * sin_p;
        if (t.pole_top) begin
          t.nx = '0; t.ny = UNIT_POS; t.nz = '0;
        end else if (t.pole_bot) begin
          t.nx = '0; t.ny = UNIT_NEG; t.nz = '0;
        end else begin
          t.nx = clamp_unit(rnd_shift(40'(prx), 5'd14));
          t.ny = cos_t;
          t.nz = clamp_unit(rnd_shift(40'(prz), 5'd14));
        end
      end
      if (g == S_POS) begin
        qx = t.nx * rad;
        qy = t.ny * rad;
        qz = t.nz * rad;
        t.px = 17'(rnd_shift(40'(qx), 5'd14));
        t.py = 17'(rnd_shift(40'(qy), 5'd14));
        t.pz = 17'(rnd_shift(40'(qz), 5'd14));
        if (rev_r) begin
          t.nx = -t.nx; t.ny = -t.ny; t.nz = -t.nz;
        end
      end
      pipe_nxt[g] = t;
    end
  end

  assign ph_t = pipe_r[S_DIV].num[0][31:0];
  assign ph_p = pipe_r[S_DIV].num[1][31:0] + 32'h4000_0000;

  uvsg_cordic u_cordic_theta (
    .clk(clk), .en(adv), .phase_i(ph_t), .cos_o(cos_t), .sin_o(sin_t)
  );

  uvsg_cordic u_cordic_phi (
    .clk(clk), .en(adv), .phase_i(ph_p), .cos_o(cos_p), .sin_o(sin_p)
  );

  assign out_last = !(out_item_r.mode && !out_item_r.bad) || (cnt_r == 3'd5);
  // the whole pipe moves together; hold while a result waits
  assign adv      = !out_valid_r || (out_tready && out_last);
  assign in_tready = rst_n && adv;
  assign cnt_nxt  = adv ? 3'd0 : ((out_valid_r && out_tready) ? cnt_r + 3'd1 : cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NST; g++) vld_r[g] <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (adv) begin
        vld_r[0] <= in_tvalid;
        for (int g = 1; g < NST; g++) vld_r[g] <= vld_r[g-1];
        out_valid_r <= vld_r[NST-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < NST; g++) pipe_r[g] <= pipe_nxt[g];
      out_item_r <= pipe_r[NST-1];
    end
  end

  always_comb begin
    logic [15:0] p1, p2, p3, p4, idx;
    p1 = out_item_r.vidx;
    p2 = p1 + {7'd0, out_item_r.s1};
    p3 = p1 + 16'd1;
    p4 = p2 + 16'd1;
    case (cnt_r)
      3'd0: idx = p1;
      3'd1: idx = rev_r ? p3 : p2;
      3'd2: idx = rev_r ? p2 : p3;
      3'd3: idx = p3;
      3'd4: idx = rev_r ? p4 : p2;
      default: idx = rev_r ? p2 : p4;
    endcase
    out_tvalid = out_valid_r;
    out_tlast  = out_last;
    out_tuser  = out_item_r.bad;
    if (out_item_r.bad) begin
      out_tdata = '0;
    end else if (out_item_r.mode) begin
      out_tdata = {136'd0, idx};
    end else begin
      out_tdata = {3'd0, out_item_r.num[3][16:0], out_item_r.num[2][16:0],
                   out_item_r.pz, out_item_r.py, out_item_r.px,
                   out_item_r.nz, out_item_r.ny, out_item_r.nx, out_item_r.vidx};
    end
  end

endmodule

// ----- design/uvsg_cordic.sv -----
// Pipelined CORDIC: cosine and sine in Q1.14 of a 32-bit turn phase.
// Depends on uvsg_pkg. The stages advance only while en is high.
module uvsg_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase_i,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);
  import uvsg_pkg::*;

  typedef struct packed {
    logic [1:0]         q;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } rot_t;

  rot_t rot_r [0:8];
  rot_t rot_nxt [0:8];
  logic signed [15:0] cos_nxt, sin_nxt;

  always_comb begin
    logic [31:0]        qsum;
    logic [31:0]        d;
    rot_t               t;
    logic signed [33:0] xs, ys;
    logic signed [32:0] at;
    int                 i;
    qsum = phase_i + 32'h2000_0000;
    d    = phase_i - {qsum[31:30], 30'd0};
    rot_nxt[0].q = qsum[31:30];
    rot_nxt[0].x = CORDIC_GAIN;
    rot_nxt[0].y = '0;
    rot_nxt[0].z = 33'($signed(d));
    for (int k = 1; k <= 8; k++) begin
      t = rot_r[k-1];
      for (int j = 0; j < 2; j++) begin
        i  = 2 * (k - 1) + j;
        xs = t.x >>> i;
        ys = t.y >>> i;
        at = $signed({1'b0, ATAN_PHASE[4'(i)]});
        if (t.z >= 0) begin
          t.x = t.x - ys;
          t.y = t.y + xs;
          t.z = t.z - at;
        end else begin
          t.x = t.x + ys;
          t.y = t.y - xs;
          t.z = t.z + at;
        end
      end
      rot_nxt[k] = t;
    end
  end

  always_comb begin
    logic signed [15:0] cc, ss;
    cc = clamp_unit(rnd_shift(40'(rot_r[8].x), 5'd16));
    ss = clamp_unit(rnd_shift(40'(rot_r[8].y), 5'd16));
    // rotate back by the quarter turns split off at the start
    unique case (rot_r[8].q)
      2'd0: begin cos_nxt = cc;  sin_nxt = ss;  end
      2'd1: begin cos_nxt = -ss; sin_nxt = cc;  end
      2'd2: begin cos_nxt = -cc; sin_nxt = -ss; end
      default: begin cos_nxt = ss; sin_nxt = -cc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= 8; k++) rot_r[k] <= rot_nxt[k];
      cos_o <= cos_nxt;
      sin_o <= sin_nxt;
    end
  end

endmodule

// ----- design/uvsg_checker.sv -----
// Port-level checker of the sphere vertex generator, bound to the top level.
// Depends on uv_sphere_vertex_index_generator_core_defines.svh.
`include "uv_sphere_vertex_index_generator_core_defines.svh"

module uvsg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata,
  input logic [0:0]   out_tuser,
  input logic         out_tlast
);

  `UVSG_ASSERT_NEXT_ALL(a_rst_empty, clk, !rst_n, !out_tvalid, "output valid after reset")
  `UVSG_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled item changed")
  `UVSG_ASSERT_SAME(a_bad_single, clk, rst_n, out_tvalid && out_tuser[0], out_tlast, "bad request not single")
  `UVSG_ASSERT_SAME(a_bad_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0, "bad request carries data")
  `UVSG_ASSERT_SAME(a_quad_zero, clk, rst_n, out_tvalid && !out_tlast, out_tdata[151:16] == '0, "index item carries vertex data")

endmodule

bind uv_sphere_vertex_index_generator_core uvsg_checker u_uvsg_checker (.*);

// ----- bench/tb_uv_sphere_vertex_index_generator_core.sv -----
// Self-checking bench for the UV-sphere vertex and quad index generator.
// Predicts every result in fixed point and compares the streamed output field by field.
// Depends on uvsg_pkg and uv_sphere_vertex_index_generator_core.
module tb_uv_sphere_vertex_index_generator_core;
  import uvsg_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;   // stack_index[7:0], slice_index[15:8]
  logic [0:0]   in_tuser;   // mode[0]
  logic         out_tvalid;
  logic         out_tready;
  // vert_num[15:0], normal_x[31:16], normal_y[47:32], normal_z[63:48],
  // position_x[80:64], position_y[97:81], position_z[114:98],
  // tex_u[131:115], tex_v[148:132], zero[151:149]
  logic [151:0] out_tdata;
  logic [0:0]   out_tuser;  // bad_request[0]
  logic         out_tlast;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_wdata;

  typedef struct {
    logic [15:0]        vidx;
    logic signed [15:0] nx, ny, nz;
    logic signed [16:0] px, py, pz;
    logic [16:0]        tu, tv;
    logic               bad, last;
  } vertex_rec_t;

  vertex_rec_t pending_verts[$];

  // shadow copies of the block's registers
  logic [15:0] sph_radius;
  logic [7:0]  sph_slices;
  logic [7:0]  sph_stacks;
  logic        sph_reverse;

  int  mismatches;
  int  cycle_count;
  bit  idle_on;
  int  hold_req;
  int  hold_left;
  int  stall_left;

  uv_sphere_vertex_index_generator_core u_top (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_uv_sphere_vertex_index_generator_core NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_req;
      hold_req = 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= int'($urandom_range(0, 9));
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic longint round_away(longint v, int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic int to_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return int'(v);
  endfunction

  // CORDIC sine/cosine of a 2^32-per-turn phase, Q1.14
  task automatic sin_cos(input logic [31:0] phase, output int cv, output int sv);
    logic [31:0] shifted, resid;
    logic [1:0]  quad;
    longint      x, y, z, xs, ys;
    int          cc, ss;
    shifted = phase + 32'h2000_0000;
    quad = shifted[31:30];
    resid = phase - {quad, 30'd0};
    z = longint'($signed(resid));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_PHASE[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_PHASE[i]);
      end
    end
    cc = to_unit(round_away(x, 16));
    ss = to_unit(round_away(y, 16));
    case (quad)
      2'd0: begin cv = cc;  sv = ss;  end
      2'd1: begin cv = -ss; sv = cc;  end
      2'd2: begin cv = -cc; sv = -ss; end
      default: begin cv = ss; sv = -cc; end
    endcase
  endtask

  // expected results of one accepted item
  task automatic predict_sphere(input logic mode, input logic [7:0] st, input logic [7:0] sl);
    vertex_rec_t r;
    longint      sc, tc, p1, p2, p3, p4;
    longint      seq[6];
    int          nrm[3];
    int          ct, sth, cp, sp;
    logic [31:0] tphase, pphase;
    bit          bad;
    sc = sph_slices;
    tc = sph_stacks;
    r = '{default: '0};
    if (mode == 1'b0) bad = (sc == 0 || tc == 0 || st > tc || sl > sc);
    else bad = (sc == 0 || tc == 0 || st >= tc || sl >= sc);
    if (bad) begin
      r.bad = 1'b1;
      r.last = 1'b1;
      pending_verts.push_back(r);
      return;
    end
    if (mode == 1'b0) begin
      if (st == 0) nrm = '{0, 16384, 0};
      else if (st == tc) nrm = '{0, -16384, 0};
      else begin
        tphase = 32'(((longint'(st) << 31) + tc / 2) / tc);
        pphase = 32'h4000_0000 + 32'(((longint'(sl) << 32) + sc / 2) / sc);
        sin_cos(tphase, ct, sth);
        sin_cos(pphase, cp, sp);
        nrm[0] = to_unit(round_away(longint'(sth) * cp, 14));
        nrm[1] = ct;
        nrm[2] = to_unit(round_away(longint'(sth) * sp, 14));
      end
      r.vidx = 16'(longint'(st) * (sc + 1) + sl);
      r.px = 17'(round_away(longint'(nrm[0]) * sph_radius, 14));
      r.py = 17'(round_away(longint'(nrm[1]) * sph_radius, 14));
      r.pz = 17'(round_away(longint'(nrm[2]) * sph_radius, 14));
      r.nx = 16'(sph_reverse ? -nrm[0] : nrm[0]);
      r.ny = 16'(sph_reverse ? -nrm[1] : nrm[1]);
      r.nz = 16'(sph_reverse ? -nrm[2] : nrm[2]);
      r.tu = 17'(((longint'(sl) << 16) + sc / 2) / sc);
      r.tv = 17'(((longint'(st) << 16) + tc / 2) / tc);
      r.last = 1'b1;
      pending_verts.push_back(r);
      return;
    end
    p1 = sl + longint'(st) * (sc + 1);
    p2 = p1 + sc + 1;
    p3 = p1 + 1;
    p4 = p2 + 1;
    if (sph_reverse) seq = '{p1, p3, p2, p3, p4, p2};
    else seq = '{p1, p2, p3, p3, p2, p4};
    for (int k = 0; k < 6; k++) begin
      r.vidx = 16'(seq[k]);
      r.last = (k == 5);
      pending_verts.push_back(r);
    end
  endtask

  task automatic cmp_field(input string name, input logic [16:0] expv, input logic [16:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    vertex_rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verts.size() == 0) begin
        $error("result with no expectation waiting");
        mismatches++;
      end else begin
        e = pending_verts.pop_front();
        cmp_field("vert_num", {1'b0, e.vidx}, {1'b0, out_tdata[15:0]});
        cmp_field("normal_x", {1'b0, e.nx}, {1'b0, out_tdata[31:16]});
        cmp_field("normal_y", {1'b0, e.ny}, {1'b0, out_tdata[47:32]});
        cmp_field("normal_z", {1'b0, e.nz}, {1'b0, out_tdata[63:48]});
        cmp_field("position_x", e.px, out_tdata[80:64]);
        cmp_field("position_y", e.py, out_tdata[97:81]);
        cmp_field("position_z", e.pz, out_tdata[114:98]);
        cmp_field("tex_u", e.tu, out_tdata[131:115]);
        cmp_field("tex_v", e.tv, out_tdata[148:132]);
        cmp_field("zero_pad", 17'd0, {14'd0, out_tdata[151:149]});
        cmp_field("bad_request", {16'd0, e.bad}, {16'd0, out_tuser[0]});
        cmp_field("last", {16'd0, e.last}, {16'd0, out_tlast});
      end
    end
  end

  task automatic send_item(input logic mode, input logic [7:0] st, input logic [7:0] sl);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {sl, st};
    do @(posedge clk); while (!in_tready);
    predict_sphere(mode, st, sl);
    // drop valid for a burst now and then
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leave the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_RADIUS:  sph_radius = val;
      CFG_SLICES:  sph_slices = val[7:0];
      CFG_STACKS:  sph_stacks = val[7:0];
      CFG_REVERSE: sph_reverse = val[0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(input logic [15:0] rad, input logic [7:0] sc, input logic [7:0] tc,
                            input logic rev);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_SLICES, {8'd0, sc});
    write_reg(CFG_STACKS, {8'd0, tc});
    write_reg(CFG_REVERSE, {15'd0, rev});
    cfg_we <= 1'b0;
  endtask

  // mostly in range, some just past the edge, a few anywhere
  task automatic send_random(input int count);
    logic [7:0] st, sl;
    int         pick;
    for (int n = 0; n < count; n++) begin
      pick = int'($urandom_range(0, 9));
      if (pick == 0) begin
        st = 8'($urandom_range(0, 255));
        sl = 8'($urandom_range(0, 255));
      end else begin
        st = 8'($urandom_range(0, (sph_stacks == 8'd255) ? 255 : sph_stacks + 1));
        sl = 8'($urandom_range(0, (sph_slices == 8'd255) ? 255 : sph_slices + 1));
      end
      send_item(1'($urandom_range(0, 1)), st, sl);
    end
  endtask

  task automatic test_directed();
    send_item(1'b0, 8'd0, 8'd0);
    send_item(1'b0, 8'd16, 8'd16);
    send_item(1'b0, 8'd8, 8'd4);
    send_item(1'b0, 8'd3, 8'd11);
    send_item(1'b0, 8'd17, 8'd0);
    send_item(1'b0, 8'd0, 8'd17);
    send_item(1'b0, 8'd255, 8'd255);
    send_item(1'b1, 8'd0, 8'd0);
    send_item(1'b1, 8'd15, 8'd15);
    send_item(1'b1, 8'd16, 8'd0);
    send_item(1'b1, 8'd0, 8'd16);
    send_item(1'b1, 8'd7, 8'd9);
    wait_drained();
    set_sphere(16'hFFFF, 8'd255, 8'd255, 1'b1);
    send_item(1'b0, 8'd255, 8'd255);
    send_item(1'b0, 8'd0, 8'd255);
    send_item(1'b0, 8'd128, 8'd200);
    send_item(1'b1, 8'd254, 8'd254);
    send_item(1'b1, 8'd255, 8'd3);
    send_item(1'b1, 8'd10, 8'd20);
    wait_drained();
  endtask

  task automatic test_degenerate_counts();
    set_sphere(16'd0, 8'd0, 8'd5, 1'b0);
    send_item(1'b0, 8'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd0);
    wait_drained();
    set_sphere(16'd512, 8'd1, 8'd1, 1'b0);
    send_item(1'b0, 8'd0, 8'd1);
    send_item(1'b0, 8'd1, 8'd0);
    send_item(1'b1, 8'd0, 8'd0);
    wait_drained();
    set_sphere(16'd300, 8'd7, 8'd0, 1'b1);
    send_item(1'b0, 8'd0, 8'd3);
    wait_drained();
  endtask

  task automatic test_random_settings();
    set_sphere(16'd256, 8'd16, 8'd16, 1'b0);
    send_random(40);
    wait_drained();
    set_sphere(16'd0, 8'd2, 8'd2, 1'b1);
    send_random(25);
    wait_drained();
    set_sphere(16'($urandom_range(0, 65535)), 8'($urandom_range(2, 255)),
               8'($urandom_range(2, 255)), 1'($urandom_range(0, 1)));
    send_random(40);
    wait_drained();
    set_sphere(16'($urandom_range(0, 65535)), 8'($urandom_range(2, 12)),
               8'($urandom_range(2, 12)), 1'($urandom_range(0, 1)));
    send_random(40);
    wait_drained();
  endtask

  // receiver holds off while quads keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 300;
    for (int n = 0; n < 20; n++)
      send_item(1'b1, 8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)));
    wait_drained();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    set_sphere(16'($urandom_range(0, 65535)), 8'($urandom_range(2, 40)),
               8'($urandom_range(2, 40)), 1'b0);
    send_random(40);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    hold_req = 0;
    hold_left = 0;
    stall_left = 0;
    sph_radius = 16'd256;
    sph_slices = 8'd16;
    sph_stacks = 8'd16;
    sph_reverse = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_degenerate_counts();
    set_sphere(16'd256, 8'd6, 8'd6, 1'b0);
    test_backpressure();
    test_random_settings();
    test_full_rate();
    if (mismatches == 0) begin
      $display("tb_uv_sphere_vertex_index_generator_core OK");
    end else begin
      $display("tb_uv_sphere_vertex_index_generator_core NOT OK");
    end
    $finish;
  end

endmodule
